FILE: hw/rtl/fsa_pkg.sv
// Shared widths, operation codes and result type of the fragmenting space allocator.
package fsa_pkg;

    localparam int OP_W     = 2;
    localparam int ID_W     = 10;
    localparam int TOTAL_W  = 13;
    localparam int RUN_W    = 12;
    localparam int FCNT_W   = 10;

    localparam int MAX_UNITS_DEF = 4096;
    localparam int MAX_FILES_DEF = 1024;
    localparam int TOTAL_RST_CAP = 4096;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;

    typedef struct packed {
        logic                no_space;
        logic [TOTAL_W-1:0]  first_address;
        logic [RUN_W-1:0]    run_count;
        logic [FCNT_W-1:0]   file_count;
    } t_rsp_data;

endpackage

FILE: hw/rtl/fsa_if.sv
// Request, response and configuration channels of the allocator.
interface fsa_req_if;
    import fsa_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    file_id;
    logic [TOTAL_W-1:0] size_units;
    logic [TOTAL_W-1:0] range_start;
    logic [TOTAL_W-1:0] range_end;

    modport source (output valid, op, file_id, size_units, range_start, range_end,
                    input ready);
    modport sink   (input valid, op, file_id, size_units, range_start, range_end,
                    output ready);
endinterface

interface fsa_rsp_if;
    import fsa_pkg::*;
    logic               valid;
    logic               ready;
    logic               no_space;
    logic [TOTAL_W-1:0] first_address;
    logic [RUN_W-1:0]   run_count;
    logic [FCNT_W-1:0]  file_count;

    modport source (output valid, no_space, first_address, run_count, file_count,
                    input ready);
    modport sink   (input valid, no_space, first_address, run_count, file_count,
                    output ready);
endinterface

interface fsa_cfg_if;
    import fsa_pkg::*;
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_units;

    modport source (output valid, total_units, input ready);
    modport sink   (input valid, total_units, output ready);
endinterface

FILE: hw/rtl/fsa_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module fsa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/fragmenting_space_allocator_core.sv
// Top level of the fragmenting first-fit space allocator.
// The store holds unit addresses 1..total_units, each owned by a file id or free. Add gives
// a file the lowest free units (possibly in several pieces) and returns the first address,
// or flags no_space and changes nothing; remove frees a file's units and returns how many
// contiguous runs it held; count returns how many distinct files own a unit in a closed
// address range. All work goes through one address counter and compare unit that walks the
// owner RAM one entry per cycle, so one item is in flight at a time and the request side is
// not ready meanwhile. An add walks up to its last granted unit, a remove walks the whole store,
// and a count first sweeps the seen-file map clear and then walks the range; a refused or
// trivial item goes straight to the result. After reset and after every total_units write a
// clearing pass over all MAX_UNITS entries zeroes the owner RAM; no request beat is taken
// during it, configuration beats still are. A finished result sits in an output register, so
// the next request may be taken while it waits for the sink.
module fragmenting_space_allocator_core #(
    parameter int MAX_UNITS = fsa_pkg::MAX_UNITS_DEF,
    parameter int MAX_FILES = fsa_pkg::MAX_FILES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fsa_cfg_if.sink         i_cfg,
    fsa_req_if.sink         i_req,
    fsa_rsp_if.source       o_rsp
);
    import fsa_pkg::*;

    // Address widths of the two RAMs; the walk counter covers both and any valid unit index.
    localparam int AW  = $clog2(MAX_UNITS);
    localparam int OW  = $clog2(MAX_FILES);
    localparam int IW0 = (AW > OW) ? AW : OW;
    localparam int IW  = (IW0 > TOTAL_W) ? IW0 : TOTAL_W;

    localparam logic [AW-1:0]      LAST_UNIT = AW'(MAX_UNITS - 1);
    localparam logic [OW-1:0]      LAST_FILE = OW'(MAX_FILES - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_RST =
        TOTAL_W'((MAX_UNITS < TOTAL_RST_CAP) ? MAX_UNITS : TOTAL_RST_CAP);

    typedef enum logic [4:0] {
        S_CLEAR    = 5'b00001,
        S_IDLE     = 5'b00010,
        S_SEEN_CLR = 5'b00100,
        S_SCAN     = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    // Control state
    t_state              r_state, n_state;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [TOTAL_W-1:0]  r_free, n_free;
    logic                r_iss, n_iss;
    logic                r_p_v, n_p_v;
    logic                r_q_v, n_q_v;
    logic                r_out_v, n_out_v;

    // Working payload
    logic [OP_W-1:0]     r_op, n_op;
    logic [OW-1:0]       r_id, n_id;
    logic [TOTAL_W-1:0]  r_left, n_left;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_lim, n_lim;
    logic [IW-1:0]       r_start, n_start;
    logic [IW-1:0]       r_p_idx, n_p_idx;
    logic                r_p_last, n_p_last;
    logic                r_prev, n_prev;
    logic                r_first_v, n_first_v;
    logic [RUN_W-1:0]    r_runs, n_runs;
    logic [FCNT_W-1:0]   r_fcnt, n_fcnt;
    logic [OW-1:0]       r_q_owner, n_q_owner;
    logic                r_q_fwd, n_q_fwd;
    logic                r_q_last, n_q_last;
    t_rsp_data           r_res, n_res;
    t_rsp_data           r_out, n_out;

    // RAM ports
    logic                own_we;
    logic [AW-1:0]       own_waddr;
    logic [OW-1:0]       own_wdata;
    logic [AW-1:0]       own_raddr;
    logic [OW-1:0]       own_q;
    logic                seen_we;
    logic [OW-1:0]       seen_waddr;
    logic                seen_wdata;
    logic [OW-1:0]       seen_raddr;
    logic                seen_q;

    // Request decode helpers
    logic                id_ok;
    logic [TOTAL_W-1:0]  cnt_s;
    logic [TOTAL_W-1:0]  cnt_e;
    logic [TOTAL_W-1:0]  cfg_v;
    logic                owner_ok;
    logic                q_hit;
    logic                mine;

    fsa_ram #(.WIDTH(OW), .DEPTH(MAX_UNITS)) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (own_raddr),
        .o_rdata (own_q)
    );

    fsa_ram #(.WIDTH(1), .DEPTH(MAX_FILES)) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (seen_we),
        .i_waddr (seen_waddr),
        .i_wdata (seen_wdata),
        .i_raddr (seen_raddr),
        .o_rdata (seen_q)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid         = r_out_v;
    assign o_rsp.no_space      = r_out.no_space;
    assign o_rsp.first_address = r_out.first_address;
    assign o_rsp.run_count     = r_out.run_count;
    assign o_rsp.file_count    = r_out.file_count;

    assign id_ok = (i_req.file_id != '0) && (int'(i_req.file_id) < MAX_FILES);
    // Clip the count range to the live store
    assign cnt_s = (i_req.range_start == '0) ? TOTAL_W'(1) : i_req.range_start;
    assign cnt_e = (i_req.range_end > r_total) ? r_total : i_req.range_end;

    // Saturate the written unit total into 1..MAX_UNITS
    always_comb begin
        cfg_v = i_cfg.total_units;
        if (cfg_v == '0) begin
            cfg_v = TOTAL_W'(1);
        end else if (int'(cfg_v) > MAX_UNITS) begin
            cfg_v = TOTAL_W'(MAX_UNITS);
        end
    end

    // Seen-map stage: a file counts once; forward the write made in the cycle its read issued
    assign owner_ok = (r_q_owner != '0) && (int'(r_q_owner) < MAX_FILES);
    assign q_hit    = r_q_v && owner_ok && !(seen_q || r_q_fwd);
    assign mine     = (own_q == r_id);

    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_free    = r_free;
        n_iss     = r_iss;
        n_p_v     = r_p_v;
        n_q_v     = r_q_v;
        n_out_v   = r_out_v;
        n_op      = r_op;
        n_id      = r_id;
        n_left    = r_left;
        n_idx     = r_idx;
        n_lim     = r_lim;
        n_start   = r_start;
        n_p_idx   = r_p_idx;
        n_p_last  = r_p_last;
        n_prev    = r_prev;
        n_first_v = r_first_v;
        n_runs    = r_runs;
        n_fcnt    = r_fcnt;
        n_q_owner = r_q_owner;
        n_q_fwd   = r_q_fwd;
        n_q_last  = r_q_last;
        n_res     = r_res;
        n_out     = r_out;

        own_we     = 1'b0;
        own_waddr  = r_idx[AW-1:0];
        own_wdata  = '0;
        own_raddr  = r_idx[AW-1:0];
        seen_we    = 1'b0;
        seen_waddr = r_q_owner;
        seen_wdata = 1'b0;
        seen_raddr = own_q;

        // Release the output register when the sink takes the beat
        if (r_out_v && o_rsp.ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // Zero the owner RAM one entry per cycle
                own_we    = 1'b1;
                own_waddr = r_idx[AW-1:0];
                own_wdata = '0;
                if (r_idx[AW-1:0] == LAST_UNIT) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            S_IDLE: begin
                if (i_req.valid) begin
                    n_res   = '0;
                    n_state = S_DONE;
                    n_p_v   = 1'b0;
                    n_q_v   = 1'b0;
                    n_op    = i_req.op;
                    n_id    = OW'(i_req.file_id);
                    n_idx   = '0;
                    n_lim   = IW'(r_total - TOTAL_W'(1));
                    unique case (i_req.op)
                        OP_ADD: begin
                            if (!id_ok || i_req.size_units == '0) begin
                                n_res = '0;
                            end else if (i_req.size_units > r_free) begin
                                n_res.no_space = 1'b1;
                            end else begin
                                n_free    = r_free - i_req.size_units;
                                n_left    = i_req.size_units;
                                n_first_v = 1'b0;
                                n_iss     = 1'b1;
                                n_state   = S_SCAN;
                            end
                        end
                        OP_REMOVE: begin
                            if (id_ok) begin
                                n_prev  = 1'b0;
                                n_runs  = '0;
                                n_iss   = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        OP_COUNT: begin
                            if (cnt_s <= cnt_e) begin
                                n_start = IW'(cnt_s - TOTAL_W'(1));
                                n_lim   = IW'(cnt_e - TOTAL_W'(1));
                                n_fcnt  = '0;
                                n_state = S_SEEN_CLR;
                            end
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end

            S_SEEN_CLR: begin
                // Wipe the seen-file map, then start the walk at the range start
                seen_we    = 1'b1;
                seen_waddr = r_idx[OW-1:0];
                seen_wdata = 1'b0;
                if (r_idx[OW-1:0] == LAST_FILE) begin
                    n_idx   = r_start;
                    n_iss   = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            S_SCAN: begin
                // Issue: one owner read per cycle until the last index
                n_q_v = 1'b0;
                if (r_iss) begin
                    own_raddr = r_idx[AW-1:0];
                    n_p_v     = 1'b1;
                    n_p_idx   = r_idx;
                    n_p_last  = (r_idx == r_lim);
                    if (r_idx == r_lim) begin
                        n_iss = 1'b0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else begin
                    n_p_v = 1'b0;
                end

                unique case (r_op)
                    OP_ADD: begin
                        if (r_p_v && own_q == '0) begin
                            own_we    = 1'b1;
                            own_waddr = r_p_idx[AW-1:0];
                            own_wdata = r_id;
                            n_left    = r_left - TOTAL_W'(1);
                            if (!r_first_v) begin
                                n_first_v           = 1'b1;
                                n_res.first_address = r_p_idx[TOTAL_W-1:0] + TOTAL_W'(1);
                            end
                            if (r_left == TOTAL_W'(1)) begin
                                n_state = S_DONE;
                                n_iss   = 1'b0;
                                n_p_v   = 1'b0;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (r_p_v) begin
                            n_prev = mine;
                            if (mine) begin
                                own_we    = 1'b1;
                                own_waddr = r_p_idx[AW-1:0];
                                own_wdata = '0;
                                n_free    = r_free + TOTAL_W'(1);
                                if (!r_prev) begin
                                    n_runs = r_runs + RUN_W'(1);
                                end
                            end
                            if (r_p_last) begin
                                n_res.run_count = n_runs;
                                n_state         = S_DONE;
                                n_iss           = 1'b0;
                                n_p_v           = 1'b0;
                            end
                        end
                    end
                    OP_COUNT: begin
                        // Seen-map update for the owner held in the lookup stage (r_q_owner)
                        if (q_hit) begin
                            seen_we    = 1'b1;
                            seen_waddr = r_q_owner;
                            seen_wdata = 1'b1;
                            n_fcnt     = r_fcnt + FCNT_W'(1);
                        end
                        // Seen-map lookup for the owner just read
                        if (r_p_v) begin
                            seen_raddr = own_q;
                            n_q_v      = 1'b1;
                            n_q_owner  = own_q;
                            n_q_last   = r_p_last;
                            n_q_fwd    = q_hit && (r_q_owner == own_q);
                        end
                        if (r_q_v && r_q_last) begin
                            n_res.file_count = n_fcnt;
                            n_state          = S_DONE;
                            n_iss            = 1'b0;
                            n_p_v            = 1'b0;
                            n_q_v            = 1'b0;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                        n_iss   = 1'b0;
                        n_p_v   = 1'b0;
                    end
                endcase
            end

            S_DONE: begin
                // Hand the result over once the output register is free
                if (!r_out_v || o_rsp.ready) begin
                    n_out   = r_res;
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A total_units write restarts the store from empty
        if (i_cfg.valid) begin
            n_total = cfg_v;
            n_free  = cfg_v;
            n_idx   = '0;
            n_iss   = 1'b0;
            n_p_v   = 1'b0;
            n_q_v   = 1'b0;
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_total <= TOTAL_RST;
            r_free  <= TOTAL_RST;
            r_iss   <= 1'b0;
            r_p_v   <= 1'b0;
            r_q_v   <= 1'b0;
            r_out_v <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_free  <= n_free;
            r_iss   <= n_iss;
            r_p_v   <= n_p_v;
            r_q_v   <= n_q_v;
            r_out_v <= n_out_v;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_id      <= n_id;
        r_left    <= n_left;
        r_lim     <= n_lim;
        r_start   <= n_start;
        r_p_idx   <= n_p_idx;
        r_p_last  <= n_p_last;
        r_prev    <= n_prev;
        r_first_v <= n_first_v;
        r_runs    <= n_runs;
        r_fcnt    <= n_fcnt;
        r_q_owner <= n_q_owner;
        r_q_fwd   <= n_q_fwd;
        r_q_last  <= n_q_last;
        r_res     <= n_res;
        r_out     <= n_out;
    end

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the fragmenting first-fit space allocator core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fsa_pkg::*;

    localparam int NUM_UNITS   = MAX_UNITS_DEF;
    localparam int NUM_FILES   = MAX_FILES_DEF;
    // Longest single beat: the seen-map sweep plus a full-store range.
    localparam int TAIL_CYCLES = NUM_FILES + NUM_UNITS + 16;
    // Give up after this many cycles in which no beat moves on any channel.
    localparam int STALL_LIMIT = 4 * TAIL_CYCLES;
    localparam int MAX_SHOWN   = 10;
    localparam int ID_POOL     = 24;

    // Op code 3 is not decoded by the block; it must answer all zero.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    file_id;
        logic [TOTAL_W-1:0] size_units;
        logic [TOTAL_W-1:0] range_start;
        logic [TOTAL_W-1:0] range_end;
    } t_alloc_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fsa_req_if req_ch();
    fsa_rsp_if rsp_ch();
    fsa_cfg_if cfg_ch();

    fragmenting_space_allocator_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the store: owner per unit address (0 = free), usable size
    // and the number of free units left.
    logic [ID_W-1:0] owner_of [1:NUM_UNITS];
    int unsigned     store_size;
    int unsigned     free_left;

    // Responses still owed by the block, oldest first.
    t_rsp_data pending_rsp [$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int n_add = 0, n_remove = 0, n_count = 0, n_other = 0;
    int n_refused = 0, n_cfg = 0, n_rsp = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // Saturate the written size into 1..NUM_UNITS and wipe the store.
    function automatic void apply_total_units(logic [TOTAL_W-1:0] value);
        int unsigned v;
        v = value;
        if (v < 1) v = 1;
        if (v > NUM_UNITS) v = NUM_UNITS;
        store_size = v;
        free_left  = v;
        foreach (owner_of[a]) owner_of[a] = '0;
    endfunction

    // Apply one command to the shadow store and return the response it owes.
    function automatic t_rsp_data alloc_response(t_alloc_cmd c);
        t_rsp_data   r;
        int          a;
        int          lo;
        int          hi;
        int unsigned left;
        logic        prev_mine;
        logic        mine;
        bit          seen [NUM_FILES];
        r = '0;
        case (c.op)
            OP_ADD: begin
                n_add++;
                // Zero id or zero size: nothing is granted and nothing is flagged.
                if (c.file_id != '0 && c.size_units != '0) begin
                    if (c.size_units > free_left) begin
                        r.no_space = 1'b1;
                        n_refused++;
                    end else begin
                        // First fit: take the lowest free units, skipping owned ones.
                        left = c.size_units;
                        for (a = 1; a <= int'(store_size) && left > 0; a++) begin
                            if (owner_of[a] == '0) begin
                                owner_of[a] = c.file_id;
                                if (r.first_address == '0) r.first_address = TOTAL_W'(a);
                                left--;
                            end
                        end
                        free_left -= c.size_units;
                    end
                end
            end
            OP_REMOVE: begin
                n_remove++;
                if (c.file_id != '0) begin
                    // Count maximal runs while freeing the file's units.
                    prev_mine = 1'b0;
                    for (a = 1; a <= int'(store_size); a++) begin
                        mine = (owner_of[a] == c.file_id);
                        if (mine) begin
                            if (!prev_mine) r.run_count++;
                            owner_of[a] = '0;
                            free_left++;
                        end
                        prev_mine = mine;
                    end
                end
            end
            OP_COUNT: begin
                n_count++;
                // Clip the range to the store; an empty range counts nothing.
                lo = (c.range_start < 1) ? 1 : int'(c.range_start);
                hi = (c.range_end > store_size) ? int'(store_size) : int'(c.range_end);
                for (a = lo; a <= hi; a++) begin
                    if (owner_of[a] != '0 && !seen[owner_of[a]]) begin
                        seen[owner_of[a]] = 1'b1;
                        r.file_count++;
                    end
                end
            end
            default: n_other++;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------

    function automatic void flag_mismatch(string what, t_rsp_data want, t_rsp_data got);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%0t: response mismatch (%s)", $realtime, what);
            $display("    expected no_space=%0b first_address=%0d run_count=%0d file_count=%0d",
                     want.no_space, want.first_address, want.run_count, want.file_count);
            $display("    actual   no_space=%0b first_address=%0d run_count=%0d file_count=%0d",
                     got.no_space, got.first_address, got.run_count, got.file_count);
        end
    endfunction

    // Compare every accepted response beat with the oldest pending one.
    always @(posedge i_clk) begin : rsp_check
        t_rsp_data got;
        t_rsp_data want;
        string     bad;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_rsp++;
            got.no_space      = rsp_ch.no_space;
            got.first_address = rsp_ch.first_address;
            got.run_count     = rsp_ch.run_count;
            got.file_count    = rsp_ch.file_count;
            if (pending_rsp.size() == 0) begin
                flag_mismatch("response with nothing pending", '0, got);
            end else begin
                want = pending_rsp.pop_front();
                bad  = "";
                if (got.no_space !== want.no_space) bad = {bad, " no_space"};
                if (got.first_address !== want.first_address) bad = {bad, " first_address"};
                if (got.run_count !== want.run_count) bad = {bad, " run_count"};
                if (got.file_count !== want.file_count) bad = {bad, " file_count"};
                if (bad != "") flag_mismatch({"wrong", bad}, want, got);
            end
        end
    end

    // Drop the run when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d responses pending",
                         quiet_cycles, pending_rsp.size());
                $display("** fragmenting_space_allocator_core: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: toggle ready at random per cycle at the current stall rate.
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    // Offer one request beat, idling first at the current rate. Valid is left
    // high after the accepting edge; the next call overwrites or lowers it, and drain_results lowers it.
    task automatic send_cmd(t_alloc_cmd c);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= c.op;
        req_ch.file_id     <= c.file_id;
        req_ch.size_units  <= c.size_units;
        req_ch.range_start <= c.range_start;
        req_ch.range_end   <= c.range_end;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.insert(pending_rsp.size(), alloc_response(c));
    endtask

    task automatic add_file(logic [ID_W-1:0] id, logic [TOTAL_W-1:0] size);
        t_alloc_cmd c;
        c = '{OP_ADD, id, size, '0, '0};
        send_cmd(c);
    endtask

    task automatic remove_file(logic [ID_W-1:0] id);
        t_alloc_cmd c;
        c = '{OP_REMOVE, id, '0, '0, '0};
        send_cmd(c);
    endtask

    task automatic count_files(logic [TOTAL_W-1:0] first, logic [TOTAL_W-1:0] last);
        t_alloc_cmd c;
        c = '{OP_COUNT, '0, '0, first, last};
        send_cmd(c);
    endtask

    // Hold requests off until every owed response has come back.
    task automatic drain_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Write total_units with the block idle; the block then clears its store.
    task automatic write_total_units(logic [TOTAL_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.total_units <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_total_units(value);
        n_cfg++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Field extremes on add at the reset size of 4096 units.
    task automatic test_add_edges();
        add_file(10'd1, 13'd1);
        add_file(10'd1023, 13'd3);
        add_file(10'd7, 13'd8191);      // far beyond the store: refused
        add_file(10'd8, 13'd4096);      // one full store, but units are taken
        add_file(10'd0, 13'd5);         // zero id: ignored
        add_file(10'd5, 13'd0);         // zero size: nothing granted
    endtask

    // Punch a hole, refill it across the gap, re-add a live file.
    task automatic test_fragmentation();
        add_file(10'd2, 13'd2);
        add_file(10'd3, 13'd2);
        add_file(10'd2, 13'd1);         // live file grows in a second piece
        remove_file(10'd3);
        add_file(10'd9, 13'd5);         // fills the hole, then splits
        remove_file(10'd2);
        remove_file(10'd9);
        remove_file(10'd9);             // already gone
        remove_file(10'd0);
    endtask

    // Count with clipped, single-unit, empty and out-of-store ranges, then send an unknown op.
    task automatic test_count_ranges();
        t_alloc_cmd c;
        count_files(13'd0, 13'd8191);
        count_files(13'd2, 13'd2);
        count_files(13'd5, 13'd4);
        count_files(13'd5000, 13'd8191);
        c.op          = OP_UNKNOWN;
        c.file_id     = ID_W'($urandom_range(1, 1023));
        c.size_units  = TOTAL_W'($urandom_range(1, 8191));
        c.range_start = TOTAL_W'($urandom_range(1, 100));
        c.range_end   = TOTAL_W'($urandom_range(100, 8191));
        send_cmd(c);
    endtask

    // Size register at both saturation points.
    task automatic test_config_extremes();
        write_total_units(13'd0);       // saturates to a single unit
        add_file(10'd4, 13'd1);
        add_file(10'd5, 13'd1);
        count_files(13'd1, 13'd8191);
        write_total_units(13'd8191);    // saturates to the full store
        add_file(10'd6, 13'd4096);
        remove_file(10'd6);
    endtask

    // One phase of random traffic: mostly well-formed commands on a small id
    // pool so adds, removes and counts interact; the rest is raw noise.
    task automatic run_random_phase(int idle, int stall, logic [TOTAL_W-1:0] units,
                                    int items, bit pause_midway);
        t_alloc_cmd c;
        int         pick;
        int         cap;
        int         k;
        write_total_units(units);
        idle_pct  = idle;
        stall_pct = stall;
        cap = (store_size / 6 > 1) ? int'(store_size / 6) : 1;
        for (k = 0; k < items; k++) begin
            if (pause_midway && k == items / 2) drain_results();
            pick          = $urandom_range(0, 99);
            c.file_id     = ID_W'($urandom_range(1, ID_POOL));
            c.size_units  = TOTAL_W'($urandom_range(1, cap));
            c.range_start = TOTAL_W'($urandom_range(1, store_size));
            c.range_end   = TOTAL_W'($urandom_range(c.range_start, store_size));
            if (pick < 45) begin
                c.op = OP_ADD;
            end else if (pick < 70) begin
                c.op = OP_REMOVE;
            end else if (pick < 90) begin
                c.op = OP_COUNT;
            end else begin
                c.op          = OP_W'($urandom_range(0, 3));
                c.file_id     = ID_W'($urandom_range(0, 1023));
                c.size_units  = TOTAL_W'($urandom_range(0, 8191));
                c.range_start = TOTAL_W'($urandom_range(0, 8191));
                c.range_end   = TOTAL_W'($urandom_range(0, 8191));
            end
            send_cmd(c);
        end
    endtask

    // Four random phases with varied idle and stall rates and store sizes.
    task automatic test_random_traffic();
        run_random_phase(0, 0, TOTAL_W'($urandom_range(16, 128)), 29, 1'b0);
        run_random_phase(63, 0, 13'd4096, 29, 1'b1);
        run_random_phase(0, 63, TOTAL_W'($urandom_range(1, 16)), 29, 1'b0);
        run_random_phase(27, 27, TOTAL_W'($urandom_range(0, 8191)), 29, 1'b0);
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_ADD;
        req_ch.file_id     = '0;
        req_ch.size_units  = '0;
        req_ch.range_start = '0;
        req_ch.range_end   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.total_units = '0;
        i_rst_n            = 1'b0;
        apply_total_units(TOTAL_W'(TOTAL_RST_CAP));

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_add_edges();
        test_fragmentation();
        test_count_ranges();
        test_config_extremes();
        test_random_traffic();

        // Let every owed response land, then watch for strays.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d adds (%0d refused), %0d removes, %0d counts, %0d other ops",
                 n_add, n_refused, n_remove, n_count, n_other);
        $display("run: %0d size writes, %0d responses checked, %0d mismatches",
                 n_cfg, n_rsp, mismatches);
        if (mismatches == 0) begin
            $display("** fragmenting_space_allocator_core: PASSED **");
        end else begin
            $display("** fragmenting_space_allocator_core: FAILED **");
        end
        $finish;
    end

endmodule
